// ===== hw/rtl/lps_pkg.sv =====
package lps_pkg;

    // State codes, as reported on the result channel
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECIDE  = 4'd1;
    localparam logic [3:0] ST_P1_ON   = 4'd2;
    localparam logic [3:0] ST_P1_OFF  = 4'd3;
    localparam logic [3:0] ST_P2_ON   = 4'd4;
    localparam logic [3:0] ST_P2_OFF  = 4'd5;
    localparam logic [3:0] ST_P3_ON   = 4'd6;
    localparam logic [3:0] ST_P3_OFF  = 4'd7;
    localparam logic [3:0] ST_P4_ON   = 4'd8;
    localparam logic [3:0] ST_P4_OFF  = 4'd9;
    localparam logic [3:0] ST_INIT    = 4'd10;

    // Pattern numbers
    localparam logic [3:0] PAT_NONE  = 4'd0;
    localparam logic [3:0] PAT_HALF  = 4'd1;
    localparam logic [3:0] PAT_CHECK = 4'd2;
    localparam logic [3:0] PAT_WALK  = 4'd3;
    localparam logic [3:0] PAT_PAIR  = 4'd4;

    localparam logic [7:0] LED_HALF_A  = 8'hF0;
    localparam logic [7:0] LED_HALF_B  = 8'h0F;
    localparam logic [7:0] LED_CHECK_A = 8'hAA;
    localparam logic [7:0] LED_CHECK_B = 8'h55;
    localparam logic [7:0] LED_PAIR_A  = 8'hCC;
    localparam logic [7:0] LED_PAIR_B  = 8'h33;
    localparam logic [7:0] WALK_START  = 8'h80;
    localparam logic [7:0] WALK_END    = 8'h01;

    typedef struct packed {
        logic [3:0] fsm_state;
        logic [7:0] latched_command;
        logic [3:0] speed_index;
        logic [3:0] pattern_number;
        logic [7:0] hold_count;
        logic [7:0] walking_bit;
        logic       phase_toggle;
        logic [7:0] led_hold;
    } lps_state_t;

    // Hold length per speed index; indexes above five clamp to the fastest
    function automatic logic [7:0] hold_limit(input logic [3:0] speed);
        logic [7:0] lim;
        case (speed)
            4'd0:    lim = 8'd40;
            4'd1:    lim = 8'd20;
            4'd2:    lim = 8'd10;
            4'd3:    lim = 8'd5;
            4'd4:    lim = 8'd2;
            default: lim = 8'd1;
        endcase
        return lim;
    endfunction

endpackage

// ===== hw/rtl/lps_step.sv =====
module lps_step (
    input  lps_pkg::lps_state_t cur,
    input  logic [7:0]          rx,
    output lps_pkg::lps_state_t nxt
);
    import lps_pkg::*;

    logic       same;
    logic [3:0] s;

    always_comb
    begin
        nxt  = cur;
        same = (rx == cur.latched_command);
        s    = cur.fsm_state;

        // Transitions
        unique case (cur.fsm_state) inside
            ST_INIT:
            begin
                s = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cur.latched_command != 8'd0)
                begin
                    s                  = ST_DECIDE;
                    nxt.speed_index    = cur.latched_command[3:0];
                    nxt.pattern_number = cur.latched_command[7:4];
                end
            end
            ST_DECIDE:
            begin
                if (!same || cur.pattern_number == PAT_NONE)
                begin
                    s = ST_IDLE;
                end
                else if (cur.pattern_number <= PAT_PAIR)
                begin
                    if (cur.pattern_number == PAT_WALK)
                        nxt.walking_bit = WALK_START;
                    nxt.hold_count = 8'd0;
                    s = {cur.pattern_number[2:0], 1'b0};
                end
                // unknown pattern: stay until the command changes
            end
            ST_P1_ON, ST_P1_OFF, ST_P2_ON, ST_P2_OFF,
            ST_P3_ON, ST_P3_OFF, ST_P4_ON, ST_P4_OFF:
            begin
                if (!same)
                begin
                    s = ST_IDLE;
                end
                else if (!cur.fsm_state[0])
                begin
                    s              = cur.fsm_state + 4'd1;
                    nxt.hold_count = 8'd0;
                end
                else if (cur.hold_count >= hold_limit(cur.speed_index))
                begin
                    if (cur.fsm_state != ST_P3_OFF)
                        nxt.hold_count = 8'd0;
                    s = cur.fsm_state - 4'd1;
                end
            end
            default:
            begin
                s = ST_INIT;
            end
        endcase
        nxt.fsm_state = s;

        // Actions on the new state
        case (s) inside
            ST_IDLE:
            begin
                nxt.latched_command = rx;
            end
            ST_P1_ON:
            begin
                nxt.led_hold     = cur.phase_toggle ? LED_HALF_B : LED_HALF_A;
                nxt.phase_toggle = ~cur.phase_toggle;
            end
            ST_P2_ON:
            begin
                nxt.led_hold     = cur.phase_toggle ? LED_CHECK_B : LED_CHECK_A;
                nxt.phase_toggle = ~cur.phase_toggle;
            end
            ST_P3_ON:
            begin
                nxt.led_hold    = nxt.walking_bit;
                nxt.walking_bit = (nxt.walking_bit == WALK_END) ? WALK_START
                                                                : (nxt.walking_bit >> 1);
            end
            ST_P4_ON:
            begin
                nxt.led_hold     = cur.phase_toggle ? LED_PAIR_B : LED_PAIR_A;
                nxt.phase_toggle = ~cur.phase_toggle;
            end
            ST_P1_OFF, ST_P2_OFF, ST_P3_OFF, ST_P4_OFF:
            begin
                nxt.hold_count = nxt.hold_count + 8'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/led_pattern_sequencer_core.sv =====
// LED pattern sequencer. Each request on the slave stream is one tick that
// carries the latest received command byte; each tick yields exactly one
// result on the master stream with the held LED byte and the state code
// (0 idle, 1 decide, 2..9 pattern on/off, 10 init). A nonzero command seen in
// idle is split into a speed index (low nibble, clamped to 5) and a pattern
// number (high nibble, 1..4); the pattern runs while the incoming byte keeps
// matching, and any change returns the block to idle. Throughput is one tick
// per clock: the next-state logic is a single compare/shift pass from the
// state registers to the result register, so a tick is accepted every cycle
// while the result register is empty or being drained, and its result
// appears in the next cycle. No clearing pass follows reset.
module led_pattern_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] received_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] led_byte, [11:8] state_code, [15:12] zero
);
    import lps_pkg::*;

    lps_state_t    st_reg;
    lps_state_t    st_next;
    logic          out_valid_reg;
    logic [15:0]   out_data_reg;
    logic          s_accept;

    // Take a tick whenever the result register is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    lps_step u_step (
        .cur (st_reg),
        .rx  (s_tdata),
        .nxt (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.fsm_state       <= ST_INIT;
            st_reg.latched_command <= 8'd0;
            st_reg.speed_index     <= 4'd0;
            st_reg.pattern_number  <= 4'd0;
            st_reg.hold_count      <= 8'd0;
            st_reg.walking_bit     <= 8'd0;
            st_reg.phase_toggle    <= 1'b0;
            st_reg.led_hold        <= 8'd0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                // Advance the sequencer and load the result together
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                // Drop the result once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_accept)
            out_data_reg <= {4'd0, st_next.fsm_state, st_next.led_hold};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The state register never leaves the defined codes
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.fsm_state <= ST_INIT)
        else $error("sequencer state outside defined codes");

    // Every accepted tick produces a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid)
        else $error("accepted tick produced no result");

    // The walking pattern always holds exactly one lit bit
    a_walk_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.fsm_state == ST_P3_ON || st_reg.fsm_state == ST_P3_OFF)
        |-> $onehot(st_reg.walking_bit))
        else $error("walking bit not one-hot");

    // The LED byte only changes on entry to a pattern step
    a_led_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.led_hold != $past(st_reg.led_hold)) |->
        (st_reg.fsm_state == ST_P1_ON || st_reg.fsm_state == ST_P2_ON ||
         st_reg.fsm_state == ST_P3_ON || st_reg.fsm_state == ST_P4_ON))
        else $error("LED byte changed outside a pattern step");

endmodule

// ===== sim/led_pattern_sequencer_core_tb.sv =====
`timescale 1ns / 100ps

// Checks the LED pattern sequencer against its own cycle model. Every tick
// request on the slave stream yields one result on the master stream, so
// each accepted tick pushes exactly one expected LED byte and state code.
module led_pattern_sequencer_core_tb;

    import lps_pkg::*;

    // One expected result: LED byte and state code
    typedef struct {
        logic [7:0] led;
        logic [3:0] code;
    } led_result_t;

    // One directed tick; known marks a result that is typed in by hand
    typedef struct {
        logic [7:0] rx;
        bit         known;
        logic [7:0] led;
        logic [3:0] code;
    } tick_row_t;

    localparam int DirectedRows = 26;
    localparam int RandomTicks  = 1450;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] received_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] led_byte, [11:8] state_code

    // Model copy of the sequencer state
    logic [3:0] seq_state   = ST_INIT;
    logic [7:0] seq_cmd     = 8'h00;
    logic [3:0] seq_speed   = 4'd0;
    logic [3:0] seq_pattern = PAT_NONE;
    logic [7:0] seq_hold    = 8'd0;
    logic [7:0] seq_walk    = 8'h00;
    logic       seq_phase   = 1'b0;
    logic [7:0] seq_led     = 8'h00;

    led_result_t results_due[$];
    tick_row_t   directed_ticks[DirectedRows];

    int  err_count   = 0;
    int  ticks_sent  = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;   // no gaps or stalls while set

    led_pattern_sequencer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Idle length for either side: mostly none, often short, sometimes long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the model by one tick and return the result it reports.
    // Transitions first, then the action of the state just entered.
    task automatic step_sequencer(input logic [7:0] rx, output led_result_t res);
        logic       same;
        logic [3:0] nxt;
        logic [7:0] limit;
        same = (rx == seq_cmd);
        nxt  = seq_state;
        // Speed table, indexes above five clamp to the one-tick hold
        case (seq_speed)
            4'd0:    limit = 8'd40;
            4'd1:    limit = 8'd20;
            4'd2:    limit = 8'd10;
            4'd3:    limit = 8'd5;
            4'd4:    limit = 8'd2;
            default: limit = 8'd1;
        endcase

        case (seq_state) inside
            ST_INIT:
                nxt = ST_IDLE;
            ST_IDLE:
                if (seq_cmd != 8'h00)
                begin
                    nxt         = ST_DECIDE;
                    seq_speed   = seq_cmd[3:0];
                    seq_pattern = seq_cmd[7:4];
                end
            ST_DECIDE:
                if (!same || seq_pattern == PAT_NONE)
                    nxt = ST_IDLE;
                else if (seq_pattern <= PAT_PAIR)
                begin
                    if (seq_pattern == PAT_WALK)
                        seq_walk = WALK_START;
                    seq_hold = 8'd0;
                    nxt      = {seq_pattern[2:0], 1'b0};
                end
                // patterns above four: hold in decide while the byte matches
            ST_P1_ON, ST_P1_OFF, ST_P2_ON, ST_P2_OFF,
            ST_P3_ON, ST_P3_OFF, ST_P4_ON, ST_P4_OFF:
                if (!same)
                    nxt = ST_IDLE;
                else if (!seq_state[0])
                begin
                    nxt      = seq_state + 4'd1;
                    seq_hold = 8'd0;
                end
                else if (seq_hold >= limit)
                begin
                    // the walking pattern keeps its hold count across steps
                    if (seq_state != ST_P3_OFF)
                        seq_hold = 8'd0;
                    nxt = seq_state - 4'd1;
                end
            default:
                nxt = ST_INIT;
        endcase
        seq_state = nxt;

        case (nxt) inside
            ST_IDLE:
                seq_cmd = rx;
            ST_P1_ON:
            begin
                seq_led   = seq_phase ? LED_HALF_B : LED_HALF_A;
                seq_phase = ~seq_phase;
            end
            ST_P2_ON:
            begin
                seq_led   = seq_phase ? LED_CHECK_B : LED_CHECK_A;
                seq_phase = ~seq_phase;
            end
            ST_P3_ON:
            begin
                seq_led  = seq_walk;
                seq_walk = (seq_walk == WALK_END) ? WALK_START : (seq_walk >> 1);
            end
            ST_P4_ON:
            begin
                seq_led   = seq_phase ? LED_PAIR_B : LED_PAIR_A;
                seq_phase = ~seq_phase;
            end
            ST_P1_OFF, ST_P2_OFF, ST_P3_OFF, ST_P4_OFF:
                seq_hold = seq_hold + 8'd1;
            default:
                ;
        endcase

        res.led  = seq_led;
        res.code = nxt;
    endtask

    // Drive one tick request, starting and ending at a falling edge. Valid
    // is lowered only when a gap precedes the request, so back-to-back
    // requests never see two assignments to it in one step.
    task automatic send_tick(input logic [7:0] rx, input bit known,
                             input logic [7:0] t_led, input logic [3:0] t_code);
        int          gap;
        led_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        step_sequencer(rx, res);
        // Hand-typed rows override the model, which still advances
        if (known)
        begin
            res.led  = t_led;
            res.code = t_code;
        end
        results_due.push_back(res);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Hold one command byte for a run of ticks
    task automatic send_run(input logic [7:0] cmd, input int len);
        repeat (len) send_tick(cmd, 1'b0, 8'h00, ST_IDLE);
    endtask

    // Result side: stall at random, with the same gap profile as the sender
    always @(negedge clk)
    begin
        if (stall_left == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        led_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: led_byte %02h state_code %0d",
                       m_tdata[7:0], m_tdata[11:8]);
                err_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (m_tdata[7:0] !== want.led)
                begin
                    $error("led_byte mismatch: expected %02h, got %02h",
                           want.led, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[11:8] !== want.code)
                begin
                    $error("state_code mismatch: expected %0d, got %0d",
                           want.code, m_tdata[11:8]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int          kind;
        logic [3:0]  pat;
        logic [3:0]  spd;
        logic [7:0]  cmd;

        // Directed walk: zero byte, each pattern, speed clamp, pattern zero,
        // pattern above four, and the first tick after reset.
        directed_ticks = '{
            '{8'h00, 1'b1, 8'h00, ST_IDLE},    // init drops to idle
            '{8'h15, 1'b1, 8'h00, ST_IDLE},    // latch, zero was latched before
            '{8'h15, 1'b1, 8'h00, ST_DECIDE},
            '{8'h15, 1'b1, LED_HALF_A, ST_P1_ON},
            '{8'h15, 1'b0, 8'h00, ST_IDLE},
            '{8'h15, 1'b0, 8'h00, ST_IDLE},
            '{8'h2F, 1'b0, 8'h00, ST_IDLE},    // change: back to idle
            '{8'h2F, 1'b0, 8'h00, ST_IDLE},    // speed fifteen clamps
            '{8'h2F, 1'b0, 8'h00, ST_IDLE},
            '{8'h2F, 1'b0, 8'h00, ST_IDLE},
            '{8'h2F, 1'b0, 8'h00, ST_IDLE},
            '{8'h3F, 1'b0, 8'h00, ST_IDLE},
            '{8'h3F, 1'b0, 8'h00, ST_IDLE},
            '{8'h3F, 1'b1, WALK_START, ST_P3_ON},
            '{8'h3F, 1'b0, 8'h00, ST_IDLE},
            '{8'h3F, 1'b0, 8'h00, ST_IDLE},    // bit rotates right
            '{8'h4E, 1'b0, 8'h00, ST_IDLE},
            '{8'h4E, 1'b0, 8'h00, ST_IDLE},
            '{8'h4E, 1'b0, 8'h00, ST_IDLE},
            '{8'h05, 1'b0, 8'h00, ST_IDLE},
            '{8'h05, 1'b0, 8'h00, ST_IDLE},    // pattern zero in decide
            '{8'h05, 1'b0, 8'h00, ST_IDLE},
            '{8'hFF, 1'b0, 8'h00, ST_IDLE},
            '{8'hFF, 1'b0, 8'h00, ST_IDLE},
            '{8'hFF, 1'b0, 8'h00, ST_IDLE},    // pattern fifteen sticks in decide
            '{8'hFF, 1'b0, 8'h00, ST_IDLE}
        };

        // Hold reset low, then release it at a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        calm = 1'b1;
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i].rx, directed_ticks[i].known,
                      directed_ticks[i].led, directed_ticks[i].code);

        // Random part: mostly held commands that run a pattern, the rest
        // noise, patterns zero or above four, and runs cut short.
        while (ticks_sent < DirectedRows + RandomTicks)
        begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                pat = 4'($urandom_range(PAT_HALF, PAT_PAIR));
                spd = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 1))
                                                  : 4'($urandom_range(2, 15));
                cmd = {pat, spd};
                if (spd <= 4'd1)
                    send_run(cmd, $urandom_range(30, 120));
                else
                    send_run(cmd, $urandom_range(3, 60));
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 6))
                    send_tick(8'($urandom_range(0, 255)), 1'b0, 8'h00, ST_IDLE);
            end
            else if (kind == 8)
            begin
                pat = ($urandom_range(0, 2) == 0) ? PAT_NONE
                                                  : 4'($urandom_range(5, 15));
                cmd = {pat, 4'($urandom_range(0, 15))};
                send_run(cmd, $urandom_range(2, 8));
            end
            else
            begin
                cmd = {4'($urandom_range(PAT_HALF, PAT_PAIR)), 4'($urandom_range(0, 15))};
                send_run(cmd, $urandom_range(1, 3));
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait until every expected result has been taken
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (results_due.size() != 0)
        begin
            $error("%0d results never arrived", results_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lps_pkg.sv
hw/rtl/lps_step.sv
hw/rtl/led_pattern_sequencer_core.sv
sim/led_pattern_sequencer_core_tb.sv
